/* sv/cbtb_pkg.sv */
// Shared types and constants of the checkerboard texture blend.
package cbtb_pkg;

  localparam int unsigned ONE_Q16   = 65536;
  localparam int unsigned SPLIT_W   = 17;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned DIV_BITS  = 17;
  localparam int unsigned DIV_FIRST = 4;
  localparam int unsigned MUL_STG   = DIV_FIRST + DIV_BITS;
  localparam int unsigned WGT_STG   = MUL_STG + 1;
  localparam int unsigned BLD_STG   = WGT_STG + 1;
  localparam int unsigned NSTAGE    = BLD_STG + 2;

  typedef enum logic [1:0] {
    REG_SPLIT_U = 2'd0,
    REG_SPLIT_V = 2'd1,
    REG_AA_MODE = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic              valid;
    logic              hard_a;
    logic              use_aa;
    logic [DATA_W-1:0] val_a;
    logic [DATA_W-1:0] val_b;
  } side_t;

endpackage

/* sv/checkerboard_texture_blend.sv */
// Checkerboard texture blend: footprint weight of texture A and linear blend of A and B.
//
// Requests enter on the in_ channel (valid/ready) with a Q16.16 texture coordinate,
// its four screen derivatives and two scalar texture values. Each request yields
// one result on the out_ channel: weight_a (Q1.16, 0..65536) and blended (Q16.16).
// Registers are written on the cfg_ channel (index 0 split_u, 1 split_v,
// 2 aa_mode); cfg_ready is always high, so write only while the block is idle.
// The pipeline has one stage for derivative magnitude, three for the per-axis
// low-side length, seventeen for the bit-per-stage restoring division of length
// by footprint width, two for the weight and two for the blend. Throughput is one
// request per cycle while the receiver keeps taking results.
// Reset (rst_n low, synchronous) empties the pipeline and loads split_u = split_v =
// 0.5 and aa_mode = 1. When the receiver holds out_ready low with a result waiting,
// the whole pipeline freezes and in_ready drops; nothing is lost or repeated.
module checkerboard_texture_blend
  import cbtb_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [DATA_W-1:0]  in_coord_u,
  input  logic signed [DATA_W-1:0]  in_coord_v,
  input  logic signed [DATA_W-1:0]  in_du_di,
  input  logic signed [DATA_W-1:0]  in_dv_di,
  input  logic signed [DATA_W-1:0]  in_du_dj,
  input  logic signed [DATA_W-1:0]  in_dv_dj,
  input  logic signed [DATA_W-1:0]  in_value_a,
  input  logic signed [DATA_W-1:0]  in_value_b,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [SPLIT_W-1:0]        out_weight_a,
  output logic signed [DATA_W-1:0]  out_blended,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [SPLIT_W-1:0]        cfg_data
);

  logic [SPLIT_W-1:0] split_r [2];
  logic               aa_mode_r;
  logic [SPLIT_W-1:0] cfg_sat;

  side_t sb_r [NSTAGE];
  logic  adv;

  // per axis datapath
  logic [15:0]        frac_r  [2];
  logic [31:0]        h_r     [2];
  logic [16:0]        n_r     [2];
  logic signed [18:0] d2_r    [2];
  logic signed [18:0] d3_r    [2];
  logic [32:0]        w2_r    [2];
  logic [32:0]        w3_r    [2];
  logic [32:0]        w4_r    [2];
  logic [34:0]        prod_r  [2];
  logic [32:0]        len_r   [2];
  logic [33:0]        rem_r   [2][DIV_BITS];
  logic [32:0]        wd_r    [2][DIV_BITS];
  logic [16:0]        q_r     [2][DIV_BITS];
  logic [33:0]        pp_r;
  logic [33:0]        qq_r;
  logic [16:0]        wgt_r;
  logic signed [49:0] wa_r;
  logic signed [49:0] wb_r;
  logic [16:0]        wgt2_r;
  logic [16:0]        out_w_r;
  logic [31:0]        out_b_r;

  logic [DATA_W-1:0]  coord [2];
  logic [DATA_W-1:0]  dd_i  [2];
  logic [DATA_W-1:0]  dd_j  [2];
  logic [31:0]        mag_i [2];
  logic [31:0]        mag_j [2];
  logic [31:0]        hmax  [2];
  logic               lo_side [2];

  assign adv       = !sb_r[NSTAGE-1].valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;
  assign cfg_sat   = (cfg_data > SPLIT_W'(ONE_Q16)) ? SPLIT_W'(ONE_Q16) : cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      split_r[0] <= SPLIT_W'(ONE_Q16 / 2);
      split_r[1] <= SPLIT_W'(ONE_Q16 / 2);
      aa_mode_r  <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SPLIT_U: split_r[0] <= cfg_sat;
        REG_SPLIT_V: split_r[1] <= cfg_sat;
        REG_AA_MODE: aa_mode_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign coord[0] = in_coord_u;
  assign coord[1] = in_coord_v;
  assign dd_i[0]  = in_du_di;
  assign dd_i[1]  = in_dv_di;
  assign dd_j[0]  = in_du_dj;
  assign dd_j[1]  = in_dv_dj;

  always_comb begin
    for (int ax = 0; ax < 2; ax++) begin
      mag_i[ax]   = dd_i[ax][31] ? (32'd0 - dd_i[ax]) : dd_i[ax];
      mag_j[ax]   = dd_j[ax][31] ? (32'd0 - dd_j[ax]) : dd_j[ax];
      hmax[ax]    = (mag_i[ax] > mag_j[ax]) ? mag_i[ax] : mag_j[ax];
      lo_side[ax] = {1'b0, coord[ax][15:0]} < split_r[ax];
    end
  end

  // sideband shift line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NSTAGE; s++) sb_r[s].valid <= 1'b0;
    end else if (adv) begin
      sb_r[0].valid  <= in_valid;
      sb_r[0].hard_a <= (lo_side[0] == lo_side[1]);
      sb_r[0].use_aa <= aa_mode_r && (hmax[0] != 32'd0) && (hmax[1] != 32'd0);
      sb_r[0].val_a  <= in_value_a;
      sb_r[0].val_b  <= in_value_b;
      for (int s = 1; s < NSTAGE; s++) sb_r[s] <= sb_r[s-1];
    end
  end

  // low-side length per axis, then restoring division
  for (genvar ax = 0; ax < 2; ax++) begin : g_axis
    logic signed [33:0] x_hi, x_lo;
    logic [17:0]        s2;
    logic [17:0]        r_hi, r_lo, m_hi, m_lo;
    logic [16:0]        n_nxt;
    logic signed [35:0] len_nxt;

    assign s2    = {split_r[ax], 1'b0};
    assign x_hi  = $signed({17'd0, frac_r[ax], 1'b0}) + $signed({2'b00, h_r[ax]});
    assign x_lo  = $signed({17'd0, frac_r[ax], 1'b0}) - $signed({2'b00, h_r[ax]});
    assign r_hi  = {1'b0, x_hi[16:0]};
    assign r_lo  = {1'b0, x_lo[16:0]};
    assign m_hi  = (r_hi < s2) ? r_hi : s2;
    assign m_lo  = (r_lo < s2) ? r_lo : s2;
    assign n_nxt = 17'(x_hi[33:17] - x_lo[33:17]);
    assign len_nxt = $signed({1'b0, prod_r[ax]}) + 36'(d3_r[ax]);

    always_ff @(posedge clk) begin
      if (adv) begin
        frac_r[ax] <= coord[ax][15:0];
        h_r[ax]    <= hmax[ax];
        n_r[ax]    <= n_nxt;
        d2_r[ax]   <= $signed({1'b0, m_hi}) - $signed({1'b0, m_lo});
        w2_r[ax]   <= {h_r[ax], 1'b0};
        prod_r[ax] <= 35'(n_r[ax] * s2);
        d3_r[ax]   <= d2_r[ax];
        w3_r[ax]   <= w2_r[ax];
        len_r[ax]  <= len_nxt[32:0];
        w4_r[ax]   <= w3_r[ax];
      end
    end

    for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
      logic [33:0] r_in;
      logic [32:0] w_in;
      logic [16:0] q_in;
      logic        bit_k;
      logic [33:0] r_sub;
      if (k == 0) begin : g_first
        assign r_in = {1'b0, len_r[ax]};
        assign w_in = w4_r[ax];
        assign q_in = '0;
      end else begin : g_next
        assign r_in = rem_r[ax][k-1];
        assign w_in = wd_r[ax][k-1];
        assign q_in = q_r[ax][k-1];
      end
      assign bit_k = r_in >= {1'b0, w_in};
      assign r_sub = bit_k ? (r_in - {1'b0, w_in}) : r_in;
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[ax][k] <= {r_sub[32:0], 1'b0};
          wd_r[ax][k]  <= w_in;
          q_r[ax][k]   <= {q_in[15:0], bit_k};
        end
      end
    end
  end

  // weight and blend
  logic [16:0]        pu, pv;
  logic [34:0]        wsum;
  logic [16:0]        w_sel;
  logic signed [50:0] bsum;

  assign pu    = q_r[0][DIV_BITS-1];
  assign pv    = q_r[1][DIV_BITS-1];
  assign wsum  = {1'b0, pp_r} + {1'b0, qq_r};
  assign w_sel = sb_r[WGT_STG-1].use_aa ? wsum[32:16] :
                 (sb_r[WGT_STG-1].hard_a ? 17'(ONE_Q16) : 17'd0);
  assign bsum  = 51'(wa_r) + 51'(wb_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      pp_r    <= 34'(pu * pv);
      qq_r    <= 34'((17'(ONE_Q16) - pu) * (17'(ONE_Q16) - pv));
      wgt_r   <= w_sel;
      wa_r    <= $signed({1'b0, wgt_r}) * $signed(sb_r[WGT_STG].val_a);
      wb_r    <= $signed({1'b0, 17'(17'(ONE_Q16) - wgt_r)}) * $signed(sb_r[WGT_STG].val_b);
      wgt2_r  <= wgt_r;
      out_w_r <= wgt2_r;
      out_b_r <= bsum[47:16];
    end
  end

  assign out_valid    = sb_r[NSTAGE-1].valid;
  assign out_weight_a = out_w_r;
  assign out_blended  = out_b_r;

  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_weight_a <= 17'(ONE_Q16))
    else $error("weight above one");

  a_full_passes_a: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_weight_a == 17'(ONE_Q16)) |-> out_blended == sb_r[NSTAGE-1].val_a)
    else $error("full weight does not pass A");

  a_zero_passes_b: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_weight_a == 17'd0) |-> out_blended == sb_r[NSTAGE-1].val_b)
    else $error("zero weight does not pass B");

  a_hard_weight: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !sb_r[NSTAGE-1].use_aa) |->
      (out_weight_a == 17'd0 || out_weight_a == 17'(ONE_Q16)))
    else $error("hard weight not 0 or 1");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("pipeline advance mismatch");

endmodule
